[sv/uad_pkg.sv]
package uad_pkg;

  localparam int NumDecDigits = 10;
  localparam int NibW         = 4;
  localparam int BcdW         = NumDecDigits * NibW;
  localparam int ValW         = 32;
  localparam int BitsPerStep  = 4;
  localparam int ConvSteps    = ValW / BitsPerStep;
  localparam int StepW        = $clog2(ConvSteps);
  localparam int IdxW         = $clog2(NumDecDigits);

  localparam logic [6:0] AsciiZero   = 7'd48;
  localparam logic [6:0] AsciiLowerA = 7'd97;
  localparam logic [NibW-1:0] DecLimit = 4'd10;
  localparam logic [NibW-1:0] DabbleMin = 4'd5;
  localparam logic [NibW-1:0] DabbleAdd = 4'd3;

  localparam logic ModeDec = 1'b0;
  localparam logic ModeHex = 1'b1;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            mode;
  } req_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
  } digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic size;
    logic emit;
  } uad_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last;
  } uad_sts_t;

endpackage

[sv/uad_ctrl.sv]
module uad_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_mode,
  output logic             req_stall,
  output logic             digit_valid,
  input  logic             digit_stall,
  input  uad_pkg::uad_sts_t sts,
  output uad_pkg::uad_cmd_t cmd
);
  import uad_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_mode == ModeHex) ? ST_SIZE : ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!digit_stall && sts.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    req_stall   = 1'b1;
    digit_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
      end
      ST_SIZE: begin
        cmd.size = 1'b1;
      end
      ST_EMIT: begin
        digit_valid = 1'b1;
        cmd.emit    = !digit_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

[sv/uad_dp.sv]
module uad_dp (
  input  logic             clk,
  input  uad_pkg::req_t    req,
  input  uad_pkg::uad_cmd_t cmd,
  output uad_pkg::uad_sts_t sts,
  output uad_pkg::digit_t  digit
);
  import uad_pkg::*;

  logic [BcdW-1:0]  digs;
  logic [BcdW-1:0]  digs_next;
  logic [ValW-1:0]  bin;
  logic [ValW-1:0]  bin_next;
  logic [StepW-1:0] step;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  top_idx;
  logic [NibW-1:0]  nib;

  // double dabble, several bits per cycle
  always_comb begin
    logic [BcdW-1:0] b;
    logic [ValW-1:0] s;
    b = digs;
    s = bin;
    for (int st = 0; st < BitsPerStep; st++) begin
      for (int d = 0; d < NumDecDigits; d++) begin
        if (b[d*NibW +: NibW] >= DabbleMin) begin
          b[d*NibW +: NibW] = b[d*NibW +: NibW] + DabbleAdd;
        end
      end
      b = {b[BcdW-2:0], s[ValW-1]};
      s = {s[ValW-2:0], 1'b0};
    end
    digs_next = b;
    bin_next  = s;
  end

  // highest nonzero digit, zero value keeps one digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NumDecDigits; d++) begin
      if (digs[d*NibW +: NibW] != '0) begin
        top_idx = IdxW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      digs <= (req.mode == ModeHex) ? BcdW'(req.value) : '0;
      bin  <= req.value;
      step <= '0;
    end else if (cmd.conv) begin
      digs <= digs_next;
      bin  <= bin_next;
      step <= step + 1'b1;
    end
    if (cmd.size) begin
      idx <= top_idx;
    end else if (cmd.emit) begin
      idx <= idx - 1'b1;
    end
  end

  always_comb begin
    nib = '0;
    for (int d = 0; d < NumDecDigits; d++) begin
      if (idx == IdxW'(d)) begin
        nib = digs[d*NibW +: NibW];
      end
    end
  end

  assign digit.digit_char = (nib < DecLimit) ? (AsciiZero + 7'(nib))
                                             : (AsciiLowerA + 7'(nib - DecLimit));
  assign digit.last_digit = (idx == '0);

  assign sts.conv_done = (step == StepW'(ConvSteps - 1));
  assign sts.last      = (idx == '0);

endmodule

[sv/unsigned_to_ascii_digits_top.sv]
// Unsigned 32-bit value to ASCII digits, decimal or lower-case hex.
//
// Request channel (req_valid / req_stall / req): one request carries a
// value and a mode (0 decimal, 1 hex). A request is taken when req_valid
// is high and req_stall low; req_stall stays high until the last digit
// of the current request has been taken.
// Digit channel (digit_valid / digit_stall / digit): one transfer per
// digit, most significant first, no leading zeros, last_digit set on the
// least significant one. A zero value gives a single '0'.
// Sequence: a hex request goes from acceptance to locating the leading
// digit, then the digit is presented; a decimal request first runs the
// double-dabble conversion at four bits per step, then the leading digit
// is located and the digit is presented.
// A new request is taken only from idle, after the last digit of the
// previous one is taken; one digit per cycle when unstalled.
// A stalled digit holds its value and the block simply waits.
// Reset (rst, synchronous) returns the controller to idle; any request in
// flight is dropped.
module unsigned_to_ascii_digits_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  uad_pkg::req_t   req,
  output logic            digit_valid,
  input  logic            digit_stall,
  output uad_pkg::digit_t digit
);
  import uad_pkg::*;

  uad_cmd_t cmd;
  uad_sts_t sts;

  uad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_mode   (req.mode),
    .req_stall  (req_stall),
    .digit_valid(digit_valid),
    .digit_stall(digit_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  uad_dp u_dp (
    .clk  (clk),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .digit(digit)
  );

  // one request in flight: never take a request while digits are out
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> req_stall)
    else $error("request accepted while digits pending");

  // a taken non-final digit is followed by another digit
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && !digit_stall && !digit.last_digit) |=> digit_valid)
    else $error("digit run broken before last digit");

  // the final digit ends the run
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && !digit_stall && digit.last_digit) |=> !digit_valid)
    else $error("digit after last digit");

  // a new request produces no digit in the cycle after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !digit_valid)
    else $error("digit too early after request");

endmodule

[sim/unsigned_to_ascii_digits_top_test.sv]
module unsigned_to_ascii_digits_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uad_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int ResetCycles   = 4;
  localparam int RandomReqs    = 360;
  localparam int MaxDigits     = 10;
  localparam logic [31:0] DecRadix = 32'd10;
  localparam logic [31:0] HexRadix = 32'd16;
  localparam int HoldoffAt     = 120;   // requests sent before the long digit hold-off
  localparam int HoldoffCycles = 300;
  localparam int PauseAt       = 250;   // requests sent before the sender drains the block
  localparam int IdleLimit     = 2000;  // cycles with no transfer on either side
  localparam int DrainCycles   = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   req_valid = 1'b0;
  logic   req_stall;
  req_t   req = '0;
  logic   digit_valid;
  logic   digit_stall = 1'b0;
  digit_t digit;

  req_t   values_to_send[$];   // requests not yet offered
  digit_t digits_due[$];       // expected digits, oldest first

  int sent_count = 0;
  int dec_count = 0;
  int hex_count = 0;
  int digits_seen = 0;
  int mismatches = 0;

  unsigned_to_ascii_digits_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit       (digit)
  );

  always #(ClkHalf) clk = ~clk;

  // Expected digit stream for one request: collect digits low first, then
  // queue them high first with the end mark on the least significant one.
  function automatic void predict_digits(input req_t r);
    logic [31:0] rest;
    logic [31:0] radix;
    logic [31:0] d;
    logic [6:0]  low_first[MaxDigits];
    int          n;
    digit_t      e;
    rest  = r.value;
    radix = (r.mode == ModeHex) ? HexRadix : DecRadix;
    n     = 0;
    while (n == 0 || (rest != 0 && n < MaxDigits)) begin
      d = rest % radix;
      if (d < DecRadix) begin
        low_first[n] = 7'(AsciiZero + d);
      end else begin
        low_first[n] = 7'(AsciiLowerA + (d - DecRadix));
      end
      rest = rest / radix;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      e.digit_char = low_first[k];
      e.last_digit = (k == 0);
      digits_due.push_back(e);
    end
  endfunction

  // Random value: mostly a random bit length so every digit count shows up,
  // sometimes at or next to a power of ten or sixteen, or near all ones.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p;
    int          w;
    int          e;
    w = $urandom_range(32, 1);
    v = $urandom;
    case ($urandom_range(9))
      0: begin
        p = 32'd1;
        e = $urandom_range(9);
        for (int i = 0; i < e; i++) p = p * DecRadix;
        v = p + 32'($urandom_range(2)) - 32'd1;
      end
      1: begin
        p = 32'd1 << (4 * $urandom_range(7));
        v = p + 32'($urandom_range(2)) - 32'd1;
      end
      2: v = 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: begin
        if (w < 32) v = v & ((32'd1 << w) - 32'd1);
      end
    endcase
    return v;
  endfunction

  function automatic req_t make_req(input logic [31:0] v, input logic m);
    req_t r;
    r.value = v;
    r.mode  = m;
    return r;
  endfunction

  // Request driver: bursts of random length, random gaps between them; a
  // held request keeps its payload until taken.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  pause_active = 0;
  bit  pause_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_digits(req);
        sent_count <= sent_count + 1;
        if (req.mode == ModeHex) hex_count <= hex_count + 1;
        else dec_count <= dec_count + 1;
      end
      // drain pause: stop offering once until every expected digit is back
      if (!pause_done && sent_count >= PauseAt) begin
        pause_active = 1;
        pause_done   = 1;
      end
      if (pause_active && digits_due.size() == 0) pause_active = 0;

      if (!(req_valid && req_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (values_to_send.size() > 0 && !pause_active) begin
          req       <= values_to_send.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Digit monitor: checks each taken digit against the oldest expectation
  // and drives its own stall pattern, plus one long hold-off.
  stall_mode_t stall_mode = STALL_NONE;
  int          seg_left = 0;
  int          beat = 0;
  int          holdoff_left = 0;
  bit          holdoff_done = 0;
  logic        stall_next;

  always @(posedge clk) begin
    if (rst) begin
      digit_stall <= 1'b0;
    end else begin
      if (digit_valid && !digit_stall) begin
        digits_seen++;
        if (digits_due.size() == 0) begin
          $error("unexpected digit: digit_char %0d last_digit %0d",
                 digit.digit_char, digit.last_digit);
          mismatches++;
        end else begin
          digit_t e;
          e = digits_due.pop_front();
          if (digit.digit_char !== e.digit_char) begin
            $error("digit_char: expected %0d, got %0d", e.digit_char, digit.digit_char);
            mismatches++;
          end
          if (digit.last_digit !== e.last_digit) begin
            $error("last_digit: expected %0d, got %0d", e.last_digit, digit.last_digit);
            mismatches++;
          end
        end
      end

      if (!holdoff_done && sent_count >= HoldoffAt) begin
        holdoff_done = 1;
        holdoff_left = HoldoffCycles;
      end
      beat++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(3));
          seg_left   = $urandom_range(80, 10);
        end else begin
          seg_left--;
        end
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(99) < 25);
          STALL_HEAVY: stall_next = ($urandom_range(99) < 75);
          default:     stall_next = (beat % 3 == 0);
        endcase
      end
      digit_stall <= stall_next;
    end
  end

  // Watchdog on cycles where neither side moves anything.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (digit_valid && !digit_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("unsigned_to_ascii_digits_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // directed: zero, single digits, digit-count boundaries, all ones, hex letters
    values_to_send.push_back(make_req(32'd0, ModeDec));
    values_to_send.push_back(make_req(32'd0, ModeHex));
    values_to_send.push_back(make_req(32'd1, ModeDec));
    values_to_send.push_back(make_req(32'd9, ModeDec));
    values_to_send.push_back(make_req(32'd10, ModeDec));
    values_to_send.push_back(make_req(32'd99, ModeDec));
    values_to_send.push_back(make_req(32'd100, ModeDec));
    values_to_send.push_back(make_req(32'd999_999_999, ModeDec));
    values_to_send.push_back(make_req(32'd1_000_000_000, ModeDec));
    values_to_send.push_back(make_req(32'hFFFF_FFFF, ModeDec));
    values_to_send.push_back(make_req(32'hFFFF_FFFF, ModeHex));
    values_to_send.push_back(make_req(32'h8000_0000, ModeDec));
    values_to_send.push_back(make_req(32'h8000_0000, ModeHex));
    values_to_send.push_back(make_req(32'd1, ModeHex));
    values_to_send.push_back(make_req(32'h9, ModeHex));
    values_to_send.push_back(make_req(32'hA, ModeHex));
    values_to_send.push_back(make_req(32'hF, ModeHex));
    values_to_send.push_back(make_req(32'h10, ModeHex));
    values_to_send.push_back(make_req(32'h0FFF_FFFF, ModeHex));
    values_to_send.push_back(make_req(32'h1000_0000, ModeHex));
    values_to_send.push_back(make_req(32'hABCD_EF01, ModeHex));
    values_to_send.push_back(make_req(32'h2345_6789, ModeHex));
    values_to_send.push_back(make_req(32'h5555_5555, ModeDec));
    values_to_send.push_back(make_req(32'hAAAA_AAAA, ModeDec));
    for (int i = 0; i < RandomReqs; i++) begin
      values_to_send.push_back(make_req(pick_value(), 1'($urandom_range(1))));
    end

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (values_to_send.size() != 0 || req_valid || digits_due.size() != 0);
    repeat (DrainCycles) @(negedge clk);

    $display("covered %0d requests (%0d decimal, %0d hex), %0d digits checked,",
             sent_count, dec_count, hex_count, digits_seen);
    $display("with sender bursts, receiver stall patterns, a long hold-off and a drain pause");
    if (mismatches == 0) begin
      $display("unsigned_to_ascii_digits_top: match");
    end else begin
      $display("unsigned_to_ascii_digits_top: mismatch");
    end
    $finish;
  end

endmodule
